/* src/mpwf_pkg.sv */
`default_nettype none
package mpwf_pkg;

	// defaults for the top-level size parameters
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_WINDOW = 8;

	// fixed widths of the port fields
	localparam int SAMPLE_W = 32;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 2;
	localparam int WIN_REG_W = 4;
	localparam int OUT_POS_W = 10;
	localparam int OFFS_W   = 3;

	localparam int QUEUE_DEPTH = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = 2'd2;

	// register reset values
	localparam logic [WIN_REG_W-1:0] RST_WINDOW_SIZE  = 4'd2;
	localparam logic [CFG_W-1:0]     RST_PLANE_WIDTH  = 11'd1024;
	localparam logic [CFG_W-1:0]     RST_PLANE_HEIGHT = 11'd1024;

	// control part of one queued operation
	typedef struct packed {
		logic              first;
		logic              last;
		logic              done;
		logic [OFFS_W-1:0] prow;
		logic [OFFS_W-1:0] pcol;
	} op_ctl_t;

	// index width for a store of n entries, at least one bit
	function automatic int addr_w(input int n);
		int r;
		r = (n > 1) ? $clog2(n) : 1;
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/mpwf_ram.sv */
`default_nettype none
module mpwf_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [mpwf_pkg::addr_w(DEPTH)-1:0]      waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [mpwf_pkg::addr_w(DEPTH)-1:0]      raddr,
	output logic [WIDTH-1:0]                        rdata
);
	import mpwf_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/mpwf_queue.sv */
`default_nettype none
module mpwf_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = mpwf_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	import mpwf_pkg::*;

	localparam int PW = addr_w(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/mpwf_front.sv */
`default_nettype none
module mpwf_front #(
	parameter int MAX_WIDTH  = mpwf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mpwf_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW = mpwf_pkg::DEF_MAX_WINDOW
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_wr_en,
	input  logic [mpwf_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [mpwf_pkg::CFG_W-1:0]                 cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic signed [mpwf_pkg::SAMPLE_W-1:0]       sample_value,
	output logic                                       op_valid,
	input  logic                                       op_ready,
	output mpwf_pkg::op_ctl_t                          op_ctl,
	output logic signed [mpwf_pkg::SAMPLE_W-1:0]       op_sample,
	output logic [mpwf_pkg::addr_w(MAX_WIDTH)-1:0]     op_oc,
	output logic [mpwf_pkg::addr_w(MAX_HEIGHT)-1:0]    op_orow
);
	import mpwf_pkg::*;

	localparam int AW  = addr_w(MAX_WIDTH);
	localparam int RW  = addr_w(MAX_HEIGHT);
	localparam int KIW = addr_w(MAX_WINDOW);
	localparam int KW  = $clog2(MAX_WINDOW + 1);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int SCW = WW + KW + 1;
	localparam int SRW = HW + KW + 1;

	logic [WIN_REG_W-1:0] win_reg_q;
	logic [CFG_W-1:0]     width_reg_q, height_reg_q;

	logic [KW-1:0] k;
	logic [WW-1:0] w;
	logic [HW-1:0] h;

	logic [AW-1:0]  col_q, win_col_q, oc_q;
	logic [RW-1:0]  row_q, win_row_q, orow_q;
	logic [KIW-1:0] jj_q, ii_q;

	logic accept, col_last, row_last, jj_last, ii_last, col_in, row_in, in_region;

	// effective sizes: zero acts as one, oversize saturates
	always_comb begin
		if (win_reg_q == '0) begin
			k = KW'(1);
		end else if (32'(win_reg_q) > 32'(MAX_WINDOW)) begin
			k = KW'(MAX_WINDOW);
		end else begin
			k = KW'(win_reg_q);
		end
		if (width_reg_q == '0) begin
			w = WW'(1);
		end else if (32'(width_reg_q) > 32'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(width_reg_q);
		end
		if (height_reg_q == '0) begin
			h = HW'(1);
		end else if (32'(height_reg_q) > 32'(MAX_HEIGHT)) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(height_reg_q);
		end
	end

	assign col_last = (SCW'(col_q) + SCW'(1) == SCW'(w));
	assign row_last = (SRW'(row_q) + SRW'(1) == SRW'(h));
	assign jj_last  = (jj_q == KIW'(k - KW'(1)));
	assign ii_last  = (ii_q == KIW'(k - KW'(1)));
	// a window counts only if it fits whole inside the plane
	assign col_in   = (SCW'(win_col_q) + SCW'(k) <= SCW'(w));
	assign row_in   = (SRW'(win_row_q) + SRW'(k) <= SRW'(h));
	assign in_region = col_in && row_in;

	assign in_ready = op_ready;
	assign accept   = in_valid && in_ready;
	assign op_valid = in_valid && in_region;

	always_comb begin
		op_ctl.first = (jj_q == '0) && (ii_q == '0);
		op_ctl.last  = jj_last && ii_last;
		// last window of the plane: no further whole window right or below
		op_ctl.done  = jj_last && ii_last
			&& (SCW'(win_col_q) + SCW'(k) + SCW'(k) > SCW'(w))
			&& (SRW'(win_row_q) + SRW'(k) + SRW'(k) > SRW'(h));
		op_ctl.prow  = OFFS_W'(ii_q);
		op_ctl.pcol  = OFFS_W'(jj_q);
	end

	assign op_sample = sample_value;
	assign op_oc     = oc_q;
	assign op_orow   = orow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_reg_q    <= RST_WINDOW_SIZE;
			width_reg_q  <= RST_PLANE_WIDTH;
			height_reg_q <= RST_PLANE_HEIGHT;
			col_q     <= '0;
			win_col_q <= '0;
			oc_q      <= '0;
			jj_q      <= '0;
			row_q     <= '0;
			win_row_q <= '0;
			orow_q    <= '0;
			ii_q      <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WINDOW_SIZE:  win_reg_q    <= WIN_REG_W'(cfg_data);
				REG_PLANE_WIDTH:  width_reg_q  <= cfg_data;
				REG_PLANE_HEIGHT: height_reg_q <= cfg_data;
				default: ;
			endcase
			// any valid register write restarts the plane
			if (cfg_index == REG_WINDOW_SIZE || cfg_index == REG_PLANE_WIDTH
					|| cfg_index == REG_PLANE_HEIGHT) begin
				col_q     <= '0;
				win_col_q <= '0;
				oc_q      <= '0;
				jj_q      <= '0;
				row_q     <= '0;
				win_row_q <= '0;
				orow_q    <= '0;
				ii_q      <= '0;
			end
		end else if (accept) begin
			if (col_last) begin
				col_q     <= '0;
				win_col_q <= '0;
				oc_q      <= '0;
				jj_q      <= '0;
				if (row_last) begin
					row_q     <= '0;
					win_row_q <= '0;
					orow_q    <= '0;
					ii_q      <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					if (ii_last) begin
						ii_q      <= '0;
						orow_q    <= orow_q + 1'b1;
						win_row_q <= row_q + 1'b1;
					end else begin
						ii_q <= ii_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (jj_last) begin
					jj_q      <= '0;
					oc_q      <= oc_q + 1'b1;
					win_col_q <= col_q + 1'b1;
				end else begin
					jj_q <= jj_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* src/mpwf_back.sv */
`default_nettype none
module mpwf_back #(
	parameter int MAX_WIDTH  = mpwf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mpwf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       op_valid,
	output logic                                       op_ready,
	input  mpwf_pkg::op_ctl_t                          op_ctl,
	input  logic signed [mpwf_pkg::SAMPLE_W-1:0]       op_sample,
	input  logic [mpwf_pkg::addr_w(MAX_WIDTH)-1:0]     op_oc,
	input  logic [mpwf_pkg::addr_w(MAX_HEIGHT)-1:0]    op_orow,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [mpwf_pkg::SAMPLE_W-1:0]       pooled_value,
	output logic [mpwf_pkg::OUT_POS_W-1:0]             out_row,
	output logic [mpwf_pkg::OUT_POS_W-1:0]             out_col,
	output logic [mpwf_pkg::OFFS_W-1:0]                peak_row_offset,
	output logic [mpwf_pkg::OFFS_W-1:0]                peak_col_offset,
	output logic                                       plane_done
);
	import mpwf_pkg::*;

	localparam int AW = addr_w(MAX_WIDTH);
	localparam int RW = addr_w(MAX_HEIGHT);
	localparam int EW = SAMPLE_W + 2 * OFFS_W;

	logic                       v_s1, fwd_s1;
	op_ctl_t                    ctl_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [AW-1:0]              oc_s1;
	logic [RW-1:0]              orow_s1;
	logic [EW-1:0]              fwd_data_s1;

	logic [EW-1:0]              rdata, stored, wdata;
	logic signed [SAMPLE_W-1:0] stored_max, new_max;
	logic [OFFS_W-1:0]          new_prow, new_pcol;
	logic                       take, fin, adv, pop;

	// stall only when a finished window has nowhere to go
	assign fin = v_s1 && (!ctl_s1.last || !out_valid || out_ready);
	assign adv = !v_s1 || fin;
	assign op_ready = adv;
	assign pop = op_valid && adv;

	mpwf_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_WIDTH)
	) u_band_ram (
		.clk  (clk),
		.we   (fin),
		.waddr(oc_s1),
		.wdata(wdata),
		.re   (pop),
		.raddr(op_oc),
		.rdata(rdata)
	);

	// the read that ran alongside a write to the same column sees old data
	assign stored     = fwd_s1 ? fwd_data_s1 : rdata;
	assign stored_max = signed'(stored[EW-1 -: SAMPLE_W]);
	assign take       = ctl_s1.first || (sample_s1 > stored_max);

	always_comb begin
		if (take) begin
			new_max  = sample_s1;
			new_prow = ctl_s1.prow;
			new_pcol = ctl_s1.pcol;
		end else begin
			new_max  = stored_max;
			new_prow = stored[2*OFFS_W-1 -: OFFS_W];
			new_pcol = stored[OFFS_W-1:0];
		end
	end

	assign wdata = {new_max, new_prow, new_pcol};

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_s1      <= op_ctl;
			sample_s1   <= op_sample;
			oc_s1       <= op_oc;
			orow_s1     <= op_orow;
			fwd_data_s1 <= wdata;
		end
		if (fin && ctl_s1.last) begin
			pooled_value    <= new_max;
			out_row         <= OUT_POS_W'(orow_s1);
			out_col         <= OUT_POS_W'(oc_s1);
			peak_row_offset <= new_prow;
			peak_col_offset <= new_pcol;
			plane_done      <= ctl_s1.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			fwd_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= pop;
			end
			if (pop) begin
				fwd_s1 <= fin && (oc_s1 == op_oc);
			end
			if (fin && ctl_s1.last) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* src/max_pool_window_forward_top.sv */
`default_nettype none
// Channel  Handshake               Words
// in       in_valid / in_ready     sample_value
// out      out_valid / out_ready   pooled_value, out_row, out_col,
//                                  peak_row_offset, peak_col_offset, plane_done
// cfg      cfg_wr_en               cfg_index, cfg_data
//
// One sample per cycle sustained while the queue has room; a window's last sample
// passes queue write, band RAM read, compare and write-back before out_valid rises.
// Forwarding lets read-modify-writes on one band RAM column run back to back.
// Reset clears counters, queue and pipeline; the band RAM needs no clearing.
// A full output register stalls the stage only while it holds a window's last sample.
module max_pool_window_forward_top #(
	parameter int MAX_WIDTH  = mpwf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mpwf_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW = mpwf_pkg::DEF_MAX_WINDOW
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [mpwf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mpwf_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [mpwf_pkg::SAMPLE_W-1:0]   sample_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mpwf_pkg::SAMPLE_W-1:0]   pooled_value,
	output logic [mpwf_pkg::OUT_POS_W-1:0]         out_row,
	output logic [mpwf_pkg::OUT_POS_W-1:0]         out_col,
	output logic [mpwf_pkg::OFFS_W-1:0]            peak_row_offset,
	output logic [mpwf_pkg::OFFS_W-1:0]            peak_col_offset,
	output logic                                   plane_done
);
	import mpwf_pkg::*;

	localparam int AW = addr_w(MAX_WIDTH);
	localparam int RW = addr_w(MAX_HEIGHT);
	localparam int QW = $bits(op_ctl_t) + SAMPLE_W + AW + RW;

	logic                       f_valid, f_ready, b_valid, b_ready;
	op_ctl_t                    f_ctl, b_ctl;
	logic signed [SAMPLE_W-1:0] f_sample, b_sample;
	logic [AW-1:0]              f_oc, b_oc;
	logic [RW-1:0]              f_orow, b_orow;
	logic [QW-1:0]              q_wdata, q_rdata;

	mpwf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_value(sample_value),
		.op_valid    (f_valid),
		.op_ready    (f_ready),
		.op_ctl      (f_ctl),
		.op_sample   (f_sample),
		.op_oc       (f_oc),
		.op_orow     (f_orow)
	);

	assign q_wdata = {f_ctl, f_sample, f_oc, f_orow};

	mpwf_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (q_wdata),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data (q_rdata)
	);

	assign {b_ctl, b_sample, b_oc, b_orow} = q_rdata;

	mpwf_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.op_valid       (b_valid),
		.op_ready       (b_ready),
		.op_ctl         (b_ctl),
		.op_sample      (b_sample),
		.op_oc          (b_oc),
		.op_orow        (b_orow),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pooled_value   (pooled_value),
		.out_row        (out_row),
		.out_col        (out_col),
		.peak_row_offset(peak_row_offset),
		.peak_col_offset(peak_col_offset),
		.plane_done     (plane_done)
	);

endmodule
`default_nettype wire
